@@ hw/rtl/frame_buffer_pool_manager_top_defines.svh @@
// ----------------------------------------------------------------------------
// frame buffer pool manager assertion macros
// shared property forms for the checker, sampled on clk, off while rst_n low
// ----------------------------------------------------------------------------
`ifndef FRAME_BUFFER_POOL_MANAGER_TOP_DEFINES_SVH
`define FRAME_BUFFER_POOL_MANAGER_TOP_DEFINES_SVH

// condition in the same cycle
`define FBPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbpm port check failed");

// condition in the following cycle
`define FBPM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbpm port check failed");

`endif

@@ hw/rtl/fbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpm_pkg
// shared widths, codes and types of the frame buffer pool manager
// ----------------------------------------------------------------------------
`default_nettype none

package fbpm_pkg;

  // pool geometry
  localparam int SLOTS    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int HANDLE_W = 32;
  localparam int REFS_W   = 7;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 3;

  localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

  // stream payload layout
  localparam int IN_BITS     = ACT_W + SLOT_W + HANDLE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = STAT_W + SLOT_W + HANDLE_W + 1;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [REFS_W-1:0]   refs_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT          = 3'd0,
    ACT_TAKE_DECODE  = 3'd1,
    ACT_ADD_REF      = 3'd2,
    ACT_DROP_REF     = 3'd3,
    ACT_MARK_OUTPUT  = 3'd4,
    ACT_TAKE_UNUSED  = 3'd5,
    ACT_RELEASE_DONE = 3'd6,
    ACT_READ_HANDLE  = 3'd7
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_VIOL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_CHECK,
    S_FREE,
    S_ALLOC,
    S_RESP
  } seq_state_t;

  // sequencer to free queue
  typedef struct packed {
    logic  push;
    logic  pop;
    slot_t push_slot;
  } q_ctl_t;

  // free queue to sequencer
  typedef struct packed {
    logic  empty;
    slot_t head;
  } q_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/frame_buffer_pool_manager_top.sv @@
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager_top
// reference counted pool of 16 frame buffer slots with a free queue
//
//   channel | dir | width | contents
//   in_     | in  | 40    | action, slot_index, buffer_handle
//   out_    | out | 40    | status, result_slot, result_handle, requeued
//
// put and release_done walk all slots through one handle comparator, one slot
// per cycle behind the registered read of the handle memory; a put that
// queues a slot adds the queue write. other actions skip the walk; a drop_ref
// that requeues adds the queue write and a free slot search. a zero handle or
// an empty queue answers straight from idle. reset clears the flags and the
// queue. in_tready is low while an item is in work; a result waiting on
// out_tready holds the item after it in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_pool_manager_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // action[2:0], slot_index[6:3], buffer_handle[38:7], zero fill[39]
  input  logic [fbpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[2:0], result_slot[6:3], result_handle[38:7], requeued[39]
  output logic [fbpm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import fbpm_pkg::*;

  // slot storage
  handle_t hdl_mem  [SLOTS];
  refs_t   refs_mem [SLOTS];
  logic [SLOTS-1:0] owned_r, owned_nxt;
  logic [SLOTS-1:0] pend_r, pend_nxt;

  // sequencer state
  seq_state_t       state_r, state_nxt;
  action_t          act_r, act_nxt;
  handle_t          h_r, h_nxt;
  slot_t            tgt_r, tgt_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fnd_r, fnd_nxt;
  logic             free_vld_r, free_vld_nxt;
  slot_t            free_r, free_nxt;
  slot_t            alloc_r, alloc_nxt;

  // registered read port
  slot_t   rd_addr;
  logic    rd_vld_r, rd_vld_nxt;
  slot_t   rd_idx_r;
  handle_t rd_hdl_r;
  refs_t   rd_refs_r;

  // result and output register
  status_t                res_st_r, res_st_nxt;
  slot_t                  res_slot_r, res_slot_nxt;
  handle_t                res_hdl_r, res_hdl_nxt;
  logic                   res_rq_r, res_rq_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // free queue
  q_ctl_t q_ctl;
  q_sts_t q_sts;

  // input decode
  action_t in_act;
  slot_t   in_idx;
  handle_t in_hdl;
  logic    in_acc, in_scan, in_take, in_hdl_zero;

  assign in_act      = action_t'(in_tdata[ACT_W-1:0]);
  assign in_idx      = in_tdata[ACT_W +: SLOT_W];
  assign in_hdl      = in_tdata[ACT_W + SLOT_W +: HANDLE_W];
  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign in_scan     = in_act inside {ACT_PUT, ACT_RELEASE_DONE};
  assign in_take     = in_act inside {ACT_TAKE_DECODE, ACT_TAKE_UNUSED};
  assign in_hdl_zero = (in_hdl == '0);

  // handle scan: the compare stage works on the read issued in the cycle before
  logic scan_issue, scan_hit, scan_free, scan_last;

  assign scan_issue = (state_r == S_SCAN) && !cnt_r[SLOT_W];
  assign scan_hit   = rd_vld_r && owned_r[rd_idx_r] && (rd_hdl_r == h_r) && !fnd_r;
  assign scan_free  = rd_vld_r && !owned_r[rd_idx_r] && !free_vld_r;
  assign scan_last  = rd_vld_r && (rd_idx_r == SLOT_W'(SLOTS - 1));
  assign rd_vld_nxt = scan_issue;
  assign rd_addr    = scan_issue ? cnt_r[SLOT_W-1:0] : tgt_r;

  // lowest free slot search after a drop frees one
  logic free_hit;
  assign free_hit = !owned_r[cnt_r[SLOT_W-1:0]];

  logic out_load;
  assign out_load = (state_r == S_RESP) && (!out_vld_r || out_tready);

  // check step: slot flags and the registered read decide the action
  logic    chk_own, chk_pend, refs_zero, refs_one, refs_full, chk_queued;
  slot_t   requeue_slot;
  status_t chk_st;
  seq_state_t chk_to;
  slot_t   chk_alloc, chk_rslot;
  handle_t chk_rh;
  logic    chk_refs_we, chk_own_clr, chk_pend_clr, chk_pend_set, chk_pop, chk_keep_h;
  refs_t   chk_refs_wd;

  assign chk_own      = owned_r[tgt_r];
  assign chk_pend     = pend_r[tgt_r];
  assign refs_zero    = (rd_refs_r == '0);
  assign refs_one     = (rd_refs_r == REFS_W'(1));
  assign refs_full    = (rd_refs_r == REFS_MAX);
  assign chk_queued   = chk_own && refs_zero && !chk_pend;
  assign requeue_slot = (free_vld_r && (free_r < tgt_r)) ? free_r : tgt_r;

  always_comb begin
    chk_st       = ST_OK;
    chk_to       = S_RESP;
    chk_alloc    = tgt_r;
    chk_rslot    = '0;
    chk_rh       = '0;
    chk_refs_we  = 1'b0;
    chk_refs_wd  = rd_refs_r;
    chk_own_clr  = 1'b0;
    chk_pend_clr = 1'b0;
    chk_pend_set = 1'b0;
    chk_pop      = 1'b0;
    chk_keep_h   = 1'b0;
    // every 4-bit slot index lies inside the pool
    case (act_r)
      ACT_PUT: begin
        if (!fnd_r) begin
          if (free_vld_r) begin
            chk_to    = S_ALLOC;
            chk_alloc = free_r;
          end else begin
            chk_st = ST_FULL;
          end
        end else if (!chk_pend) begin
          chk_st = ST_VIOL;
        end else begin
          chk_pend_clr = 1'b1;
          if (refs_zero) begin
            chk_own_clr = 1'b1;
            chk_alloc   = requeue_slot;
            chk_to      = S_ALLOC;
          end
        end
      end
      ACT_TAKE_DECODE, ACT_TAKE_UNUSED: begin
        chk_pop   = 1'b1;
        chk_rslot = tgt_r;
        chk_rh    = rd_hdl_r;
        if (act_r == ACT_TAKE_DECODE) begin
          chk_refs_we = 1'b1;
          chk_refs_wd = REFS_W'(1);
        end else begin
          chk_pend_set = 1'b1;
        end
      end
      ACT_ADD_REF: begin
        if (!chk_own || chk_queued || refs_full) begin
          chk_st = ST_VIOL;
        end else begin
          chk_refs_we = 1'b1;
          chk_refs_wd = rd_refs_r + REFS_W'(1);
        end
      end
      ACT_DROP_REF: begin
        if (!chk_own || chk_queued || refs_zero) begin
          chk_st = ST_VIOL;
        end else begin
          chk_refs_we = 1'b1;
          chk_refs_wd = rd_refs_r - REFS_W'(1);
          // last reference gone and nothing to show: back to the queue
          if (refs_one && !chk_pend) begin
            chk_own_clr = 1'b1;
            chk_keep_h  = 1'b1;
            chk_to      = S_FREE;
          end
        end
      end
      ACT_MARK_OUTPUT: begin
        if (!chk_own || chk_queued || chk_pend) begin
          chk_st = ST_VIOL;
        end else begin
          chk_pend_set = 1'b1;
        end
      end
      ACT_RELEASE_DONE: begin
        if (!fnd_r) begin
          chk_st = ST_NOTFOUND;
        end else if (!chk_pend || !refs_zero) begin
          chk_st = ST_VIOL;
        end else begin
          chk_own_clr  = 1'b1;
          chk_pend_clr = 1'b1;
        end
      end
      ACT_READ_HANDLE: begin
        if (!chk_own) begin
          chk_st = ST_VIOL;
        end else begin
          chk_rh = rd_hdl_r;
        end
      end
      default: begin
        chk_st = ST_VIOL;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_scan && in_hdl_zero) begin
            state_nxt = S_RESP;
          end else if (in_scan) begin
            state_nxt = S_SCAN;
          end else if (in_take && q_sts.empty) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = chk_to;
      S_FREE: begin
        if (free_hit) begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: state_nxt = S_RESP;
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and flag updates per state
  always_comb begin
    act_nxt      = act_r;
    h_nxt        = h_r;
    tgt_nxt      = tgt_r;
    cnt_nxt      = cnt_r;
    fnd_nxt      = fnd_r;
    free_vld_nxt = free_vld_r;
    free_nxt     = free_r;
    alloc_nxt    = alloc_r;
    owned_nxt    = owned_r;
    pend_nxt     = pend_r;
    res_st_nxt   = res_st_r;
    res_slot_nxt = res_slot_r;
    res_hdl_nxt  = res_hdl_r;
    res_rq_nxt   = res_rq_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt      = in_act;
          h_nxt        = in_hdl;
          tgt_nxt      = in_take ? q_sts.head : in_idx;
          cnt_nxt      = '0;
          fnd_nxt      = 1'b0;
          free_vld_nxt = 1'b0;
          res_slot_nxt = '0;
          res_hdl_nxt  = '0;
          res_rq_nxt   = 1'b0;
          if (in_scan && in_hdl_zero) begin
            res_st_nxt = ST_VIOL;
          end else if (in_take && q_sts.empty) begin
            res_st_nxt = ST_EMPTY;
          end else begin
            res_st_nxt = ST_OK;
          end
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (scan_hit) begin
          fnd_nxt = 1'b1;
          tgt_nxt = rd_idx_r;
        end
        if (scan_free) begin
          free_vld_nxt = 1'b1;
          free_nxt     = rd_idx_r;
        end
      end
      S_CHECK: begin
        res_st_nxt   = chk_st;
        res_slot_nxt = chk_rslot;
        res_hdl_nxt  = chk_rh;
        alloc_nxt    = chk_alloc;
        cnt_nxt      = '0;
        if (chk_own_clr) begin
          owned_nxt[tgt_r] = 1'b0;
        end
        if (chk_pend_clr) begin
          pend_nxt[tgt_r] = 1'b0;
        end
        if (chk_pend_set) begin
          pend_nxt[tgt_r] = 1'b1;
        end
        if (chk_keep_h) begin
          h_nxt = rd_hdl_r;
        end
      end
      S_FREE: begin
        if (free_hit) begin
          alloc_nxt = cnt_r[SLOT_W-1:0];
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ALLOC: begin
        owned_nxt[alloc_r] = 1'b1;
        pend_nxt[alloc_r]  = 1'b0;
        res_slot_nxt       = alloc_r;
        res_rq_nxt         = 1'b1;
      end
      S_RESP: begin
        if (out_load) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {res_rq_r, res_hdl_r, res_slot_r, res_st_r};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      owned_r    <= '0;
      pend_r     <= '0;
      cnt_r      <= '0;
      fnd_r      <= 1'b0;
      free_vld_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      owned_r    <= owned_nxt;
      pend_r     <= pend_nxt;
      cnt_r      <= cnt_nxt;
      fnd_r      <= fnd_nxt;
      free_vld_r <= free_vld_nxt;
      rd_vld_r   <= rd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    h_r        <= h_nxt;
    tgt_r      <= tgt_nxt;
    free_r     <= free_nxt;
    alloc_r    <= alloc_nxt;
    rd_idx_r   <= rd_addr;
    res_st_r   <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    res_hdl_r  <= res_hdl_nxt;
    res_rq_r   <= res_rq_nxt;
    out_data_r <= out_data_nxt;
  end

  // handle and reference memories, one write and one read port each
  logic  refs_we;
  slot_t refs_wa;
  refs_t refs_wd;

  assign refs_we = ((state_r == S_CHECK) && chk_refs_we) || (state_r == S_ALLOC);
  assign refs_wa = (state_r == S_ALLOC) ? alloc_r : tgt_r;
  assign refs_wd = (state_r == S_ALLOC) ? '0 : chk_refs_wd;

  always_ff @(posedge clk) begin
    if (state_r == S_ALLOC) begin
      hdl_mem[alloc_r] <= h_r;
    end
    if (refs_we) begin
      refs_mem[refs_wa] <= refs_wd;
    end
    rd_hdl_r  <= hdl_mem[rd_addr];
    rd_refs_r <= refs_mem[rd_addr];
  end

  // free queue
  assign q_ctl.push      = (state_r == S_ALLOC);
  assign q_ctl.pop       = (state_r == S_CHECK) && chk_pop;
  assign q_ctl.push_slot = alloc_r;

  fbpm_free_fifo u_free_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .q_ctl (q_ctl),
    .q_sts (q_sts)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/fbpm_free_fifo.sv @@
// ----------------------------------------------------------------------------
// fbpm_free_fifo
// circular queue of slot numbers that are free to use, oldest at the head
// ----------------------------------------------------------------------------
`default_nettype none

module fbpm_free_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  fbpm_pkg::q_ctl_t q_ctl,
  output fbpm_pkg::q_sts_t q_sts
);
  import fbpm_pkg::*;

  slot_t            q_mem [SLOTS];
  slot_t            rd_ptr_r, rd_ptr_nxt;
  slot_t            wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  slot_t            head_r;

  // pointer and occupancy update
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == SLOT_W'(SLOTS - 1)) ? '0 : wr_ptr_r + SLOT_W'(1);
    end
    if (q_ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == SLOT_W'(SLOTS - 1)) ? '0 : rd_ptr_r + SLOT_W'(1);
    end
    if (q_ctl.push && !q_ctl.pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (q_ctl.pop && !q_ctl.push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, head read registered behind the pointers; the sequencer
  // always spends its result step between a queue change and the next take
  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      q_mem[wr_ptr_r] <= q_ctl.push_slot;
    end
    head_r <= q_mem[rd_ptr_r];
  end

  assign q_sts.empty = (cnt_r == '0);
  assign q_sts.head  = head_r;

endmodule

`default_nettype wire

@@ hw/rtl/fbpm_checker.sv @@
// ----------------------------------------------------------------------------
// fbpm_checker
// port level checks of the frame buffer pool manager, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_buffer_pool_manager_top_defines.svh"

module fbpm_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [fbpm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import fbpm_pkg::*;

  // result fields
  logic [STAT_W-1:0]             out_st;
  logic [OUT_TDATA_W-STAT_W-1:0] out_rest;
  logic                          out_rq;

  assign out_st   = out_tdata[STAT_W-1:0];
  assign out_rest = out_tdata[OUT_TDATA_W-1:STAT_W];
  assign out_rq   = out_tdata[OUT_TDATA_W-1];

  // an action is multi-cycle: no transfer right after a transfer
  `FBPM_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // a stalled result stays put
  `FBPM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // failed actions report no slot, handle or requeue
  `FBPM_ASSERT_IMP(a_err_clean, out_tvalid && (out_st != ST_OK), out_rest == '0)

  // a requeue only comes with success
  `FBPM_ASSERT_IMP(a_requeue_ok, out_tvalid && out_rq, out_st == ST_OK)

endmodule

bind frame_buffer_pool_manager_top fbpm_checker u_fbpm_checker (.*);

`default_nettype wire

@@ dv/tb_frame_buffer_pool_manager_top.sv @@
// ----------------------------------------------------------------------------
// tb_frame_buffer_pool_manager_top
// drives put, take, reference, output-mark, release and read actions into
// the frame buffer pool manager and compares every result with a
// cycle-free model of the slot pool and its free queue kept in this bench
// ----------------------------------------------------------------------------

module tb_frame_buffer_pool_manager_top;
  import fbpm_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [4:0] LINK_NONE = 5'h1f;

  // slot selectors for stimulus
  localparam int PICK_HELD       = 0;
  localparam int PICK_REFD       = 1;
  localparam int PICK_UNMARKED   = 2;
  localparam int PICK_MARKED     = 3;
  localparam int PICK_RELEASABLE = 4;

  typedef struct {
    status_t status;
    slot_t   slot;
    handle_t handle;
    logic    requeued;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // pool image
  handle_t    pool_handle [SLOTS];
  logic       pool_owned  [SLOTS];
  refs_t      pool_refs   [SLOTS];
  logic       pool_marked [SLOTS];
  logic [4:0] pool_next   [SLOTS];
  logic [4:0] free_head;
  logic [4:0] free_tail;

  pool_result_t pending_results[$];
  int items_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int requeue_count = 0;
  int status_seen[5] = '{default: 0};
  int cycle_count = 0;
  int stall_cnt = 0;
  bit quiet = 1'b0;

  always #2 clk = ~clk;

  frame_buffer_pool_manager_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // pool model
  // ---------------------------------------------------------------------------

  function automatic void pool_clear();
    for (int i = 0; i < SLOTS; i++) begin
      pool_handle[i] = '0;
      pool_owned[i]  = 1'b0;
      pool_refs[i]   = '0;
      pool_marked[i] = 1'b0;
      pool_next[i]   = LINK_NONE;
    end
    free_head = LINK_NONE;
    free_tail = LINK_NONE;
  endfunction

  // owned, unreferenced and unmarked means sitting in the free queue
  function automatic logic in_queue(int s);
    return pool_owned[s] && pool_refs[s] == '0 && !pool_marked[s];
  endfunction

  function automatic void free_slot(int s);
    pool_handle[s] = '0;
    pool_owned[s]  = 1'b0;
    pool_refs[s]   = '0;
    pool_marked[s] = 1'b0;
    pool_next[s]   = LINK_NONE;
  endfunction

  // lowest free slot takes the handle and joins the queue tail
  function automatic int enqueue_lowest(handle_t h);
    for (int i = 0; i < SLOTS; i++) begin
      if (!pool_owned[i]) begin
        pool_handle[i] = h;
        pool_owned[i]  = 1'b1;
        pool_refs[i]   = '0;
        pool_marked[i] = 1'b0;
        pool_next[i]   = LINK_NONE;
        if (free_head == LINK_NONE || free_tail >= SLOTS) free_head = 5'(i);
        else pool_next[free_tail] = 5'(i);
        free_tail = 5'(i);
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int requeue_slot(int s);
    handle_t h;
    h = pool_handle[s];
    free_slot(s);
    return enqueue_lowest(h);
  endfunction

  function automatic int find_owned(handle_t h);
    for (int i = 0; i < SLOTS; i++)
      if (pool_owned[i] && pool_handle[i] == h) return i;
    return -1;
  endfunction

  function automatic int dequeue_head();
    int s;
    s = int'(free_head);
    free_head = pool_next[s];
    pool_next[s] = LINK_NONE;
    if (free_head == LINK_NONE) free_tail = LINK_NONE;
    return s;
  endfunction

  // result of one action, pool image updated in place
  function automatic pool_result_t apply_pool_action(action_t act, slot_t idx, handle_t h);
    pool_result_t r;
    int s;
    int i;
    r.status = ST_OK;
    r.slot = '0;
    r.handle = '0;
    r.requeued = 1'b0;
    i = int'(idx);
    case (act)
      ACT_PUT: begin
        if (h == '0) r.status = ST_VIOL;
        else begin
          s = find_owned(h);
          if (s < 0) begin
            s = enqueue_lowest(h);
            if (s < 0) r.status = ST_FULL;
            else begin
              r.slot = slot_t'(s);
              r.requeued = 1'b1;
            end
          end else if (!pool_marked[s]) r.status = ST_VIOL;
          else begin
            pool_marked[s] = 1'b0;
            if (pool_refs[s] == '0) begin
              r.slot = slot_t'(requeue_slot(s));
              r.requeued = 1'b1;
            end
          end
        end
      end
      ACT_TAKE_DECODE, ACT_TAKE_UNUSED: begin
        if (free_head >= SLOTS) r.status = ST_EMPTY;
        else begin
          s = dequeue_head();
          if (act == ACT_TAKE_DECODE) pool_refs[s] = refs_t'(1);
          else pool_marked[s] = 1'b1;
          r.slot = slot_t'(s);
          r.handle = pool_handle[s];
        end
      end
      ACT_ADD_REF, ACT_DROP_REF, ACT_MARK_OUTPUT: begin
        if (i >= SLOTS || !pool_owned[i] || in_queue(i)) r.status = ST_VIOL;
        else if (act == ACT_ADD_REF) begin
          if (pool_refs[i] >= REFS_MAX) r.status = ST_VIOL;
          else pool_refs[i] = pool_refs[i] + 1'b1;
        end else if (act == ACT_DROP_REF) begin
          if (pool_refs[i] == '0) r.status = ST_VIOL;
          else begin
            pool_refs[i] = pool_refs[i] - 1'b1;
            if (pool_refs[i] == '0 && !pool_marked[i]) begin
              r.slot = slot_t'(requeue_slot(i));
              r.requeued = 1'b1;
            end
          end
        end else begin
          if (pool_marked[i]) r.status = ST_VIOL;
          else pool_marked[i] = 1'b1;
        end
      end
      ACT_RELEASE_DONE: begin
        if (h == '0) r.status = ST_VIOL;
        else begin
          s = find_owned(h);
          if (s < 0) r.status = ST_NOTFOUND;
          else if (!pool_marked[s] || pool_refs[s] != '0) r.status = ST_VIOL;
          else free_slot(s);
        end
      end
      default: begin
        if (i >= SLOTS || !pool_owned[i]) r.status = ST_VIOL;
        else r.handle = pool_handle[i];
      end
    endcase
    return r;
  endfunction

  // random slot in a given condition, -1 when there is none
  function automatic int pick_slot(int kind);
    int cand[$];
    logic hit;
    for (int i = 0; i < SLOTS; i++) begin
      case (kind)
        PICK_HELD:     hit = pool_owned[i] && !in_queue(i);
        PICK_REFD:     hit = pool_owned[i] && pool_refs[i] != '0;
        PICK_UNMARKED: hit = pool_owned[i] && !in_queue(i) && !pool_marked[i];
        PICK_MARKED:   hit = pool_owned[i] && pool_marked[i];
        default:       hit = pool_owned[i] && pool_marked[i] && pool_refs[i] == '0;
      endcase
      if (hit) cand.push_back(i);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // stream drivers
  // ---------------------------------------------------------------------------

  // one input transfer, with an optional idle burst in front
  task automatic send_item(input action_t act, input slot_t idx, input handle_t h,
                           output pool_result_t pred);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tdata  <= {1'b0, h, idx, act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = apply_pool_action(act, idx, h);
    pending_results.push_back(pred);
    items_sent++;
  endtask

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (rst_n && !quiet && stall_cnt == 0 && $urandom_range(0, 7) == 0) begin
      stall_cnt  <= $urandom_range(1, 10);
      out_tready <= 1'b0;
    end else if (stall_cnt > 1) begin
      stall_cnt <= stall_cnt - 1;
    end else begin
      stall_cnt  <= 0;
      out_tready <= 1'b1;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    pool_result_t got;
    pool_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status   = status_t'(out_tdata[2:0]);
      got.slot     = out_tdata[6:3];
      got.handle   = out_tdata[38:7];
      got.requeued = out_tdata[39];
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d slot %0d handle %h",
                                got.status, got.slot, got.handle));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (int'(want.status) < 5) status_seen[int'(want.status)]++;
        if (want.requeued) requeue_count++;
        if (got.status !== want.status || got.slot !== want.slot ||
            got.handle !== want.handle || got.requeued !== want.requeued)
          flag_mismatch($sformatf(
            "status %0d/%0d slot %0d/%0d handle %h/%h requeued %0d/%0d (exp/act)",
            want.status, got.status, want.slot, got.slot,
            want.handle, got.handle, want.requeued, got.requeued));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every action, the empty, violation and not-found statuses and the queue corner cases on a fresh pool
  task automatic test_directed();
    pool_result_t res;
    send_item(ACT_TAKE_DECODE,  4'd0,  32'h0,         res);  // empty queue
    send_item(ACT_TAKE_UNUSED,  4'd0,  32'h0,         res);
    send_item(ACT_PUT,          4'd0,  32'h0,         res);  // zero handle
    send_item(ACT_RELEASE_DONE, 4'd0,  32'h0,         res);
    send_item(ACT_READ_HANDLE,  4'd0,  32'h0,         res);  // unowned slot
    send_item(ACT_ADD_REF,      4'd15, 32'h0,         res);
    send_item(ACT_PUT,          4'd0,  32'hFFFF_FFFF, res);
    send_item(ACT_PUT,          4'd0,  32'h0000_0001, res);
    send_item(ACT_ADD_REF,      4'd0,  32'h0,         res);  // queued slot
    send_item(ACT_READ_HANDLE,  4'd0,  32'h0,         res);
    send_item(ACT_RELEASE_DONE, 4'd0,  32'h0000_1234, res);  // unknown handle
    send_item(ACT_TAKE_DECODE,  4'd0,  32'h0,         res);
    send_item(ACT_PUT,          4'd0,  32'hFFFF_FFFF, res);  // known, not marked
    send_item(ACT_MARK_OUTPUT,  4'd0,  32'h0,         res);
    send_item(ACT_MARK_OUTPUT,  4'd0,  32'h0,         res);  // already marked
    send_item(ACT_RELEASE_DONE, 4'd0,  32'hFFFF_FFFF, res);  // still referenced
    send_item(ACT_PUT,          4'd0,  32'hFFFF_FFFF, res);  // clears mark, refs held
    send_item(ACT_DROP_REF,     4'd0,  32'h0,         res);  // back to the queue
    send_item(ACT_DROP_REF,     4'd0,  32'h0,         res);
    send_item(ACT_TAKE_UNUSED,  4'd0,  32'h0,         res);
    send_item(ACT_DROP_REF,     res.slot, 32'h0,      res);  // drop at zero refs
    send_item(ACT_RELEASE_DONE, 4'd0,  32'h0000_0001, res);
    send_item(ACT_READ_HANDLE,  4'd1,  32'h0,         res);
    send_item(ACT_TAKE_UNUSED,  4'd0,  32'h0,         res);
    send_item(ACT_PUT,          4'd0,  32'hFFFF_FFFF, res);  // marked, unreferenced
  endtask

  // SLOTS + 1 puts: fill every slot, then the rest find the pool full
  task automatic test_pool_full();
    pool_result_t res;
    handle_t h;
    for (int n = 0; n <= SLOTS; n++) begin
      h = handle_t'($urandom()) | 32'h1;
      send_item(ACT_PUT, slot_t'(n), h, res);
    end
  endtask

  // reference count up to its ceiling and one past it
  task automatic test_ref_saturation();
    pool_result_t res;
    slot_t s;
    send_item(ACT_TAKE_DECODE, 4'd0, 32'h0, res);
    s = res.slot;
    for (int n = 0; n < int'(REFS_MAX); n++) send_item(ACT_ADD_REF, s, 32'h0, res);
    send_item(ACT_DROP_REF, s, 32'h0, res);
  endtask

  // mostly well-formed pool traffic with some noise
  task automatic send_random_action();
    pool_result_t res;
    int pick;
    int s;
    action_t act;
    slot_t idx;
    handle_t h;
    pick = $urandom_range(0, 99);
    s = -1;
    act = ACT_READ_HANDLE;
    idx = slot_t'($urandom_range(0, SLOTS - 1));
    h = handle_t'($urandom());
    if (pick < 16) begin
      act = ACT_PUT;
      if ($urandom_range(0, 7) == 0) h = handle_t'($urandom_range(1, 8));
      s = 0;
    end else if (pick < 26) begin
      s = pick_slot(PICK_MARKED);
      act = ACT_PUT;
      if (s >= 0) h = pool_handle[s];
    end else if (pick < 40) begin
      act = ACT_TAKE_DECODE;
      s = 0;
    end else if (pick < 48) begin
      act = ACT_TAKE_UNUSED;
      s = 0;
    end else if (pick < 58) begin
      s = pick_slot(PICK_HELD);
      act = ACT_ADD_REF;
    end else if (pick < 72) begin
      s = pick_slot(PICK_REFD);
      act = ACT_DROP_REF;
    end else if (pick < 80) begin
      s = pick_slot(PICK_UNMARKED);
      act = ACT_MARK_OUTPUT;
    end else if (pick < 88) begin
      s = pick_slot(PICK_RELEASABLE);
      act = ACT_RELEASE_DONE;
      if (s >= 0) h = pool_handle[s];
    end else if (pick < 93) begin
      act = ACT_READ_HANDLE;
      s = 0;
    end
    if (pick >= 40 && pick < 88 && s >= 0 && act != ACT_RELEASE_DONE) idx = slot_t'(s);
    // noise, also the fallback when no slot fits
    if (s < 0) begin
      act = action_t'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 0) h = handle_t'($urandom_range(0, 8));
    end
    send_item(act, idx, h, res);
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) send_random_action();
  endtask

  // last stretch with both sides always ready
  task automatic test_back_to_back(input int count);
    quiet = 1'b1;
    for (int n = 0; n < count; n++) send_random_action();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    pool_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pool_full();
    test_ref_saturation();
    test_random_traffic(240);
    test_back_to_back(50);
    drain();

    $display("%0d actions sent, %0d results checked, %0d requeues, %0d mismatches",
             items_sent, results_checked, requeue_count, mismatches);
    $display("statuses seen: ok %0d, empty %0d, full %0d, violation %0d, not found %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
